>>> hdl/three_channel_minute_average_assert.svh
// Assertion macros for the three channel minute average block.
// Included by the top level; needs nothing else.
`ifndef THREE_CHANNEL_MINUTE_AVERAGE_ASSERT_SVH
`define THREE_CHANNEL_MINUTE_AVERAGE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCMA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcma: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TCMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcma: next-cycle check failed");

`endif

>>> hdl/tcma_pkg.sv
// Shared types and constants for the three channel minute average block.
// No dependencies.
package tcma_pkg;

  localparam int SEC_W  = 6;
  localparam int TEMP_W = 15;
  localparam int HUM_W  = 17;
  localparam int PRES_W = 17;

  localparam int WINDOW_DEFAULT = 60;

  // Reset value of the last second: matches no valid second.
  localparam logic [SEC_W-1:0] LAST_SECOND_RESET = 6'd63;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // One slot of the sample store, temperature in the low bits.
  typedef struct packed {
    logic [PRES_W-1:0] pressure;
    logic [HUM_W-1:0]  humidity;
    logic [TEMP_W-1:0] temperature;  // two's complement
  } sample_t;

endpackage

>>> hdl/tcma_slot_store.sv
// Sample store: one slot per second of the window, registered read.
// Uses tcma_pkg::sample_t. Unwritten slots read as zero.
module tcma_slot_store #(
  parameter int WINDOW = tcma_pkg::WINDOW_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(WINDOW)-1:0]  rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(WINDOW)-1:0]  wr_addr,
  input  tcma_pkg::sample_t          wr_data,
  output tcma_pkg::sample_t          rd_sample
);

  tcma_pkg::sample_t mem [WINDOW];
  tcma_pkg::sample_t rd_data;
  tcma_pkg::sample_t fwd_data;
  logic [WINDOW-1:0] vld;
  logic              rd_vld;
  logic              fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // Valid bits and bypass flag; a read that meets a write to the
  // same slot takes the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      fwd    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
        fwd    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd) begin
      rd_sample = fwd_data;
    end else if (rd_vld) begin
      rd_sample = rd_data;
    end else begin
      rd_sample = '0;
    end
  end

endmodule

>>> hdl/tcma_mean.sv
// Divide the three running sums by WINDOW: reciprocal multiply, registered.
// Uses tcma_pkg widths. Truncates toward zero; exact for every sum in range.
module tcma_mean #(
  parameter int WINDOW = tcma_pkg::WINDOW_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [tcma_pkg::TEMP_W+$clog2(WINDOW)-1:0]    temp_sum,
  input  logic [tcma_pkg::HUM_W+$clog2(WINDOW)-1:0]     hum_sum,
  input  logic [tcma_pkg::PRES_W+$clog2(WINDOW)-1:0]    pres_sum,
  output logic [tcma_pkg::TEMP_W-1:0]                   avg_temperature,
  output logic [tcma_pkg::HUM_W-1:0]                    avg_humidity,
  output logic [tcma_pkg::PRES_W-1:0]                   avg_pressure
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int TSUM_W = tcma_pkg::TEMP_W + LOG_W;
  localparam int MAG_W  = tcma_pkg::HUM_W + LOG_W;
  localparam int SH     = MAG_W + LOG_W;
  localparam int PROD_W = 2 * MAG_W + 1;
  // ceil(2^SH / WINDOW): floor(x * RECIP / 2^SH) == x / WINDOW for x < 2^MAG_W
  localparam logic [MAG_W:0] RECIP =
    (MAG_W+1)'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic              t_neg;
  logic [TSUM_W-1:0] t_abs;
  logic [PROD_W-1:0] t_prod;
  logic [PROD_W-1:0] h_prod;
  logic [PROD_W-1:0] p_prod;
  logic              t_neg_q;
  logic [tcma_pkg::TEMP_W-1:0] t_quot;

  assign t_neg = temp_sum[TSUM_W-1];
  assign t_abs = t_neg ? (~temp_sum + TSUM_W'(1)) : temp_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      t_prod  <= PROD_W'(MAG_W'(t_abs)) * PROD_W'(RECIP);
      h_prod  <= PROD_W'(hum_sum) * PROD_W'(RECIP);
      p_prod  <= PROD_W'(pres_sum) * PROD_W'(RECIP);
      t_neg_q <= t_neg;
    end
  end

  assign t_quot          = t_prod[SH +: tcma_pkg::TEMP_W];
  assign avg_temperature = t_neg_q ? (~t_quot + tcma_pkg::TEMP_W'(1)) : t_quot;
  assign avg_humidity    = h_prod[SH +: tcma_pkg::HUM_W];
  assign avg_pressure    = p_prod[SH +: tcma_pkg::PRES_W];

endmodule

>>> hdl/three_channel_minute_average.sv
// Three channel minute average: boxcar mean of temperature, humidity and pressure.
// One item per cycle unless m_tready stalls the output. A result reaches m_tvalid
// through slot read, running-sum update, reciprocal multiply and the output reg.
// A repeated second is taken and dropped with no result.
// Reset (rst, synchronous): sums zero, all slots read as zero, last second 63;
// no clearing pass, items are taken in the cycle after reset.
`include "three_channel_minute_average_assert.svh"

module three_channel_minute_average #(
  parameter int WINDOW = tcma_pkg::WINDOW_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata, low bit up: second[5:0], temperature[20:6], humidity[37:21],
  // pressure[54:38], zero pad[55]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tcma_pkg::IN_TDATA_W-1:0]     s_tdata,
  // m_tdata, low bit up: avg_temperature[14:0], avg_humidity[31:15],
  // avg_pressure[48:32], zero pad[55:49]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tcma_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int TSUM_W = tcma_pkg::TEMP_W + LOG_W;
  localparam int HSUM_W = tcma_pkg::HUM_W + LOG_W;
  localparam int PSUM_W = tcma_pkg::PRES_W + LOG_W;
  localparam int NSEC   = 2 ** tcma_pkg::SEC_W;
  localparam int OUT_USED = tcma_pkg::TEMP_W + tcma_pkg::HUM_W + tcma_pkg::PRES_W;

  // ---------------------------------------------------------------------
  // Input unpack and slot lookup (second mod WINDOW as a constant table)
  // ---------------------------------------------------------------------
  logic [tcma_pkg::SEC_W-1:0] s_second;
  tcma_pkg::sample_t          in_sample;
  logic [IDX_W-1:0]           slot_lut [NSEC];
  logic [IDX_W-1:0]           in_slot;

  assign s_second              = s_tdata[5:0];
  assign in_sample.temperature = s_tdata[20:6];
  assign in_sample.humidity    = s_tdata[37:21];
  assign in_sample.pressure    = s_tdata[54:38];

  for (genvar g = 0; g < NSEC; g++) begin : g_slot
    assign slot_lut[g] = IDX_W'(g % WINDOW);
  end

  assign in_slot = slot_lut[s_second];

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage loads when empty or when it drains.
  // ---------------------------------------------------------------------
  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready, out_ready;
  logic a_move, b_move;
  logic accept, is_new, load_a;
  logic [tcma_pkg::SEC_W-1:0] last_second;

  assign out_ready = !m_tvalid || m_tready;
  assign c_ready   = !c_valid || out_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign s_tready  = a_ready;

  assign accept = s_tvalid && s_tready;
  assign is_new = s_second != last_second;
  assign load_a = accept && is_new;     // repeated second: taken, then dropped
  assign a_move = a_valid && b_ready;   // slot write and sum update
  assign b_move = b_valid && c_ready;   // sums into the multipliers

  always_ff @(posedge clk) begin
    if (rst) begin
      last_second <= tcma_pkg::LAST_SECOND_RESET;
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (load_a) begin
        last_second <= s_second;
      end
      if (a_ready) begin
        a_valid <= load_a;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
      if (out_ready) begin
        m_tvalid <= c_valid;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: slot read in flight; the store bypasses a same-slot write.
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]  a_slot;
  tcma_pkg::sample_t a_sample;
  tcma_pkg::sample_t old_sample;

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_slot   <= in_slot;
      a_sample <= in_sample;
    end
  end

  tcma_slot_store #(
    .WINDOW (WINDOW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (load_a),
    .rd_addr   (in_slot),
    .wr_en     (a_move),
    .wr_addr   (a_slot),
    .wr_data   (a_sample),
    .rd_sample (old_sample)
  );

  // ---------------------------------------------------------------------
  // Stage B: running sums, new sample in and overwritten sample out.
  // Widths cover WINDOW full-scale samples, so no overflow.
  // ---------------------------------------------------------------------
  logic [TSUM_W-1:0] temp_sum;
  logic [HSUM_W-1:0] hum_sum;
  logic [PSUM_W-1:0] pres_sum;
  logic [TSUM_W-1:0] t_new_ext, t_old_ext;

  assign t_new_ext = {{LOG_W{a_sample.temperature[tcma_pkg::TEMP_W-1]}},
                      a_sample.temperature};
  assign t_old_ext = {{LOG_W{old_sample.temperature[tcma_pkg::TEMP_W-1]}},
                      old_sample.temperature};

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_sum <= '0;
      hum_sum  <= '0;
      pres_sum <= '0;
    end else if (a_move) begin
      temp_sum <= temp_sum + t_new_ext - t_old_ext;
      hum_sum  <= hum_sum + HSUM_W'(a_sample.humidity) - HSUM_W'(old_sample.humidity);
      pres_sum <= pres_sum + PSUM_W'(a_sample.pressure) - PSUM_W'(old_sample.pressure);
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: reciprocal products; quotients finish into the output reg.
  // ---------------------------------------------------------------------
  logic [tcma_pkg::TEMP_W-1:0] avg_temperature;
  logic [tcma_pkg::HUM_W-1:0]  avg_humidity;
  logic [tcma_pkg::PRES_W-1:0] avg_pressure;

  tcma_mean #(
    .WINDOW (WINDOW)
  ) u_mean (
    .clk             (clk),
    .en              (b_move),
    .temp_sum        (temp_sum),
    .hum_sum         (hum_sum),
    .pres_sum        (pres_sum),
    .avg_temperature (avg_temperature),
    .avg_humidity    (avg_humidity),
    .avg_pressure    (avg_pressure)
  );

  always_ff @(posedge clk) begin
    if (c_valid && out_ready) begin
      m_tdata <= {(tcma_pkg::OUT_TDATA_W - OUT_USED)'(0),
                  avg_pressure, avg_humidity, avg_temperature};
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // A repeated second leaves stage A empty.
  `TCMA_ASSERT_NEXT(a_dup_dropped, clk, rst,
                    accept && !is_new, !a_valid)
  // Sums hold while the multiplier stage is blocked.
  `TCMA_ASSERT_NEXT(b_sums_hold, clk, rst,
                    b_valid && !c_ready,
                    $stable(temp_sum) && $stable(hum_sum) && $stable(pres_sum))
  // A write to the store only comes from a full stage A.
  `TCMA_ASSERT_NOW(a_write_valid, clk, rst,
                   a_move, a_valid && b_ready)

endmodule

>>> verif/tb_minute_average_pkg.sv
// Scoreboard for the three channel minute average testbench: predicts the windowed
// means from the accepted samples and checks each average that the block emits.
// Depends on tcma_pkg for field widths and the window size.
`timescale 1ns / 100ps

package tb_minute_average_pkg;
  import tcma_pkg::*;

  // One average, laid out as in m_tdata, temperature in the low bits
  typedef struct packed {
    logic [PRES_W-1:0] avg_pressure;
    logic [HUM_W-1:0]  avg_humidity;
    logic [TEMP_W-1:0] avg_temperature;
  } minute_avg_t;

  class minute_average_scoreboard;
    logic [SEC_W-1:0]         last_second;
    logic signed [TEMP_W-1:0] temp_slots [WINDOW_DEFAULT];
    logic [HUM_W-1:0]         hum_slots [WINDOW_DEFAULT];
    logic [PRES_W-1:0]        pres_slots [WINDOW_DEFAULT];
    longint                   temp_sum;
    longint                   hum_sum;
    longint                   pres_sum;
    minute_avg_t              avg_q[$];
    int                       averages_predicted;
    int                       mismatches;

    function new();
      last_second = LAST_SECOND_RESET;
      foreach (temp_slots[i]) begin
        temp_slots[i] = '0;
        hum_slots[i]  = '0;
        pres_slots[i] = '0;
      end
      temp_sum = 0;
      hum_sum = 0;
      pres_sum = 0;
      averages_predicted = 0;
      mismatches = 0;
    endfunction

    // Accepted sample: update the running sums and queue the new means.
    // A repeated second leaves everything as it is.
    function void note_sample(input logic [SEC_W-1:0] sec,
                              input logic signed [TEMP_W-1:0] temp,
                              input logic [HUM_W-1:0] hum,
                              input logic [PRES_W-1:0] pres);
      int          slot;
      longint      mean;
      minute_avg_t avg;
      if (sec == last_second) return;
      last_second = sec;
      slot = int'(sec) % WINDOW_DEFAULT;
      temp_sum = temp_sum + longint'(temp) - longint'(temp_slots[slot]);
      hum_sum  = hum_sum + longint'(hum) - longint'(hum_slots[slot]);
      pres_sum = pres_sum + longint'(pres) - longint'(pres_slots[slot]);
      temp_slots[slot] = temp;
      hum_slots[slot]  = hum;
      pres_slots[slot] = pres;
      // longint division truncates toward zero, as the block must
      mean = temp_sum / WINDOW_DEFAULT;
      avg.avg_temperature = mean[TEMP_W-1:0];
      mean = hum_sum / WINDOW_DEFAULT;
      avg.avg_humidity = mean[HUM_W-1:0];
      mean = pres_sum / WINDOW_DEFAULT;
      avg.avg_pressure = mean[PRES_W-1:0];
      avg_q.push_back(avg);
      averages_predicted++;
    endfunction

    function void check_average(input logic [OUT_TDATA_W-1:0] tdata);
      minute_avg_t got;
      minute_avg_t want;
      got = tdata[$bits(minute_avg_t)-1:0];
      if (avg_q.size() == 0) begin
        $error("average with no sample pending: m_tdata %h", tdata);
        mismatches++;
        return;
      end
      want = avg_q.pop_front();
      if (got.avg_temperature !== want.avg_temperature) begin
        $error("avg_temperature: expected %0d, got %0d",
               $signed(want.avg_temperature), $signed(got.avg_temperature));
        mismatches++;
      end
      if (got.avg_humidity !== want.avg_humidity) begin
        $error("avg_humidity: expected %0d, got %0d", want.avg_humidity, got.avg_humidity);
        mismatches++;
      end
      if (got.avg_pressure !== want.avg_pressure) begin
        $error("avg_pressure: expected %0d, got %0d", want.avg_pressure, got.avg_pressure);
        mismatches++;
      end
    endfunction

    function int pending();
      return avg_q.size();
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
// Top of the three channel minute average testbench: clock, reset, sample source,
// average sink with random stalls, and a watchdog on stuck handshakes.
// Depends on tcma_pkg, tb_minute_average_pkg and the three_channel_minute_average RTL.
`timescale 1ns / 100ps

module tb_top;
  import tcma_pkg::*;
  import tb_minute_average_pkg::*;

  localparam int RANDOM_ITEMS    = 440;  // random part sends this many items
  localparam int CHUNK_ITEMS     = 40;   // items per idling regime on the source side
  localparam int MAX_GAP         = 18;
  localparam int RX_HOLD_CYCLES  = 300;  // long sink stall, fills the pipeline
  localparam int STALL_LIMIT     = 3000; // cycles with no handshake before giving up
  localparam int TAIL_CYCLES     = 20;   // idle tail after draining, give it plenty

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  minute_average_scoreboard sb = new();

  int tx_max_gap = 0;            // gap bound for the source, changes per chunk
  bit rx_hold_request = 1'b0;    // source asks the sink for one long stall
  int stall_cycles = 0;

  three_channel_minute_average u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run never goes this long without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one sample after a random gap and hold it until taken.
  // tvalid is left high so a back-to-back item keeps it up without a glitch.
  task automatic send_sample(input logic [SEC_W-1:0] sec,
                             input logic signed [TEMP_W-1:0] temp,
                             input logic [HUM_W-1:0] hum,
                             input logic [PRES_W-1:0] pres);
    int gap;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    // s_tdata: second, temperature, humidity, pressure from bit 0 up, one pad bit
    s_tdata  <= {1'b0, pres, hum, temp, sec};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(sec, temp, hum, pres);
  endtask

  // Source goes quiet until every predicted average has come out.
  // Always waits on a clock edge first so tvalid is not raised in the same step.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Field extremes, leap second, seconds past 60, repeats and the reset value of
  // the last second.
  task automatic directed_samples();
    tx_max_gap = MAX_GAP;
    send_sample(6'd63, 15'sd1000, 17'd50000, 17'd100000);  // matches reset: dropped
    send_sample(6'd0, 15'h4000, 17'h1ffff, 17'h1ffff);      // most negative temp, all ones
    send_sample(6'd1, 15'h3fff, 17'd0, 17'd0);              // most positive temp, zeros
    send_sample(6'd1, 15'sd123, 17'd456, 17'd789);          // repeated second: dropped
    send_sample(6'd2, -15'sd4000, 17'd100000, 17'd110000);  // spec limits
    send_sample(6'd3, 15'sd8500, 17'd0, 17'd30000);
    send_sample(6'd4, -15'sd59, 17'd59, 17'd59);            // small values, truncation
    send_sample(6'd60, -15'sd1, 17'd1, 17'd1);              // leap second, overwrites slot 0
    send_sample(6'd61, 15'h2aaa, 17'h15555, 17'h0aaaa);     // past range, slot 1
    send_sample(6'd62, 15'h5555, 17'h0aaaa, 17'h15555);
    send_sample(6'd63, 15'h4000, 17'h1ffff, 17'h1ffff);     // now differs from last: taken
    send_sample(6'd63, 15'sd0, 17'd0, 17'd0);               // repeat: dropped
    send_sample(6'd0, 15'sd2500, 17'd45000, 17'd101325);
    send_sample(6'd5, -15'sd3999, 17'd99999, 17'd109999);
    send_sample(6'd59, 15'h3fff, 17'h1ffff, 17'h1ffff);
    send_sample(6'd0, 15'h4000, 17'h1ffff, 17'd0);
    send_sample(6'd1, -15'sd1, 17'd0, 17'h1ffff);
  endtask

  // Mostly a ticking wall clock with plausible readings; some repeats, jumps,
  // leap seconds, extremes and fully random items mixed in.
  task automatic random_samples();
    int                       chunk;
    int                       roll;
    int                       value;
    logic [SEC_W-1:0]         next_sec;
    logic [SEC_W-1:0]         prev_sec;
    logic [SEC_W-1:0]         sec;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
    logic [PRES_W-1:0]        pres;
    next_sec = 6'd2;
    prev_sec = 6'd1;
    chunk = 0;
    while (chunk * CHUNK_ITEMS < RANDOM_ITEMS) begin
      if (chunk == 5) wait_drained();
      if (chunk == 2) begin
        // back-to-back source against a long sink stall
        tx_max_gap = 0;
        rx_hold_request = 1'b1;
      end else begin
        tx_max_gap = ($urandom_range(2, 0) == 0) ? 0 : MAX_GAP;
      end
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        roll = $urandom_range(99, 0);
        if (roll < 8) begin
          // noise: any bit pattern in every field
          sec  = SEC_W'($urandom);
          temp = TEMP_W'($urandom);
          hum  = HUM_W'($urandom);
          pres = PRES_W'($urandom);
        end else begin
          if (roll < 13) begin
            sec = prev_sec;
          end else if (roll < 17) begin
            sec = SEC_W'($urandom_range(63, 0));
            next_sec = (sec >= 6'd59) ? 6'd0 : sec + 6'd1;
          end else if (roll < 20) begin
            sec = 6'd60;
          end else begin
            sec = next_sec;
            next_sec = (next_sec == 6'd59) ? 6'd0 : next_sec + 6'd1;
          end
          if ($urandom_range(19, 0) == 0) begin
            temp = $urandom_range(1, 0) ? 15'h4000 : 15'h3fff;
            hum  = $urandom_range(1, 0) ? 17'h1ffff : 17'h0;
            pres = $urandom_range(1, 0) ? 17'h1ffff : 17'h0;
          end else begin
            value = int'($urandom_range(12500, 0)) - 4000;
            temp = value[TEMP_W-1:0];
            hum  = HUM_W'($urandom_range(100000, 0));
            pres = PRES_W'($urandom_range(110000, 30000));
          end
        end
        send_sample(sec, temp, hum, pres);
        prev_sec = sec;
      end
      chunk++;
    end
  endtask

  // Average sink: random stall before each item, regimes with and without stalls,
  // and one long hold when the source asks for it.
  initial begin : average_sink
    int gap;
    int taken;
    int rx_max_gap;
    taken = 0;
    rx_max_gap = 0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        gap = RX_HOLD_CYCLES;
      end else begin
        gap = $urandom_range(rx_max_gap, 0);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_average(m_tdata);
      taken++;
      if (taken % 40 == 0) rx_max_gap = $urandom_range(1, 0) ? MAX_GAP : 0;
    end
  end

  initial begin : sample_source
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    directed_samples();
    wait_drained();
    random_samples();
    wait_drained();
    // anything that shows up now has no prediction and fails in the sink
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> three_channel_minute_average.f
+incdir+hdl
hdl/tcma_pkg.sv
hdl/tcma_slot_store.sv
hdl/tcma_mean.sv
hdl/three_channel_minute_average.sv
verif/tb_minute_average_pkg.sv
verif/tb_top.sv
